// ===== src/pra_pkg.sv =====
// ----------------------------------------------------------------------------
// Page run allocator package
// Shared widths, codes and the page entry layout of the run allocator.
// ----------------------------------------------------------------------------
package pra_pkg;

    // Default number of pages in the managed region.
    localparam int PAGES_DEF = 256;

    // Fixed field widths.
    localparam int CNT_W   = 9;
    localparam int IDX_W   = 8;
    localparam int STAMP_W = 32;
    localparam int TOT_W   = 11;

    // Command codes.
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    // Result status codes.
    typedef enum logic [1:0] {
        STS_OK      = 2'd0,
        STS_NOSPACE = 2'd1,
        STS_INVALID = 2'd2
    } t_status;

    // One page entry as stored in the page memory.
    typedef struct packed {
        logic [STAMP_W-1:0] stamp;
        logic               head;
        logic               alloc;
        logic [CNT_W-1:0]   len;
    } t_page;

endpackage

// ===== src/pra_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module pra_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/pra_fit.sv =====
// ----------------------------------------------------------------------------
// Best-fit tracker
// Compares each scanned page entry against the best free run seen so far.
// ----------------------------------------------------------------------------
module pra_fit #(
    parameter int AW = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_clr,
    input  logic                  i_vld,
    input  logic [AW-1:0]         i_idx,
    input  pra_pkg::t_page        i_entry,
    input  logic [pra_pkg::CNT_W-1:0] i_cnt,
    output logic                  o_found,
    output logic [AW-1:0]         o_best,
    output logic [pra_pkg::CNT_W-1:0] o_len
);
    import pra_pkg::*;

    logic               r_found, n_found;
    logic [AW-1:0]      r_best, n_best;
    logic [CNT_W-1:0]   r_len, n_len;
    logic [STAMP_W-1:0] r_stamp, n_stamp;
    logic               w_take;

    // A free head that fits replaces the best on a shorter length, or on an
    // equal length with a later stamp.
    always_comb begin
        w_take = i_vld && i_entry.head && !i_entry.alloc && (i_entry.len >= i_cnt) &&
                 (!r_found || (i_entry.len < r_len) ||
                  ((i_entry.len == r_len) && (i_entry.stamp > r_stamp)));
        n_found = r_found;
        n_best  = r_best;
        n_len   = r_len;
        n_stamp = r_stamp;
        if (i_clr) begin
            n_found = 1'b0;
        end else if (w_take) begin
            n_found = 1'b1;
            n_best  = i_idx;
            n_len   = i_entry.len;
            n_stamp = i_entry.stamp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else begin
            r_found <= n_found;
        end
    end

    always_ff @(posedge i_clk) begin
        r_best  <= n_best;
        r_len   <= n_len;
        r_stamp <= n_stamp;
    end

    assign o_found = r_found;
    assign o_best  = r_best;
    assign o_len   = r_len;

endmodule

// ===== src/page_run_allocator.sv =====
// ----------------------------------------------------------------------------
// Page run allocator
// Best-fit page allocator with coalescing over one region of pages.
// ----------------------------------------------------------------------------
// Commands enter on the s_axis channel: tuser is the command (allocate or
// free), tdata carries the page count and the page index. Each command gives
// exactly one result on m_axis, a status and a head page index, unless a
// configuration write cuts it short. The configuration channel writes the
// region size and reinitializes the region to one free run.
// Commands are handled one at a time. An allocate scans every page of the
// region through the page memory's single read port, then passes a setup
// state and rewrites the chosen run, one page a cycle. A free reads its own
// head and, where they exist, the entry before it, the head of the run
// before and the head of the run after, then passes the setup state and
// rewrites the merged run the same way. A rejected command, a failed search
// or a finished rewrite leaves its result pending, and the next command is
// taken once that result has moved into the output register.
// After reset and after every configuration write the whole page memory is
// swept while no command is taken. The result sits in an output register;
// when the receiver stalls, the block finishes the next command and holds
// before delivering it.
// ----------------------------------------------------------------------------
module page_run_allocator #(
    parameter int PAGES = pra_pkg::PAGES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Command channel.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [8:0] page_count, [16:9] page_index
    input  logic        s_axis_tuser,   // [0] command
    // Result channel.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [1:0] status, [9:2] head_page
    // Configuration channel.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [8:0]  i_cfg_data
);
    import pra_pkg::*;

    localparam int AW   = $clog2(PAGES);
    localparam int CW   = ((AW + 1) > CNT_W) ? (AW + 1) : CNT_W;
    localparam int SUMW = ((AW > TOT_W) ? AW : TOT_W) + 1;

    typedef enum logic [9:0] {
        S_CLEAR = 10'b0000000001,
        S_IDLE  = 10'b0000000010,
        S_SCAN  = 10'b0000000100,
        S_FP    = 10'b0000001000,
        S_FQ    = 10'b0000010000,
        S_FPREV = 10'b0000100000,
        S_FNI   = 10'b0001000000,
        S_FNEXT = 10'b0010000000,
        S_WSET  = 10'b0100000000,
        S_WRITE = 10'b1000000000
    } t_state;

    // Output hand-off is folded into S_IDLE via a pending flag.
    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_pui, n_pui;
    logic               r_cmd, n_cmd;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [IDX_W-1:0]   r_pidx, n_pidx;
    logic [IDX_W-1:0]   r_prev, n_prev;
    logic [AW:0]        r_idx, n_idx;
    logic               r_vld_d, n_vld_d;
    logic [AW-1:0]      r_idx_d, n_idx_d;
    logic [AW-1:0]      r_start, n_start;
    logic [TOT_W-1:0]   r_total, n_total;
    logic [9:0]         r_next, n_next;
    logic [SUMW-1:0]    r_split, n_split;
    logic [AW:0]        r_wend, n_wend;
    logic [CNT_W-1:0]   r_len_b, n_len_b;
    logic [STAMP_W-1:0] r_stamp_w, n_stamp_w;
    logic [STAMP_W-1:0] r_ctr, n_ctr;
    logic               r_pend, n_pend;
    t_status            r_res_sts, n_res_sts;
    logic [IDX_W-1:0]   r_res_head, n_res_head;
    logic               r_out_valid, n_out_valid;
    t_status            r_out_sts, n_out_sts;
    logic [IDX_W-1:0]   r_out_head, n_out_head;

    logic [CNT_W-1:0]   w_size;
    logic               w_re, w_we;
    logic [AW-1:0]      w_raddr, w_waddr;
    t_page              w_wdata, w_rdata;
    logic               w_fit_clr, w_found;
    logic [AW-1:0]      w_best;
    logic [CNT_W-1:0]   w_best_len;
    logic [SUMW-1:0]    w_sum;
    logic               w_lo;
    logic               w_in_acc, w_out_free;

    // Effective region size: the register clamped to 1..PAGES.
    always_comb begin
        if (r_pui == '0) begin
            w_size = CNT_W'(1);
        end else if (32'(r_pui) > PAGES) begin
            w_size = CNT_W'(PAGES);
        end else begin
            w_size = r_pui;
        end
    end

    assign o_cfg_ready   = 1'b1;
    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE) && !r_pend;
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_sum         = SUMW'(r_start) + SUMW'(r_total);
    assign w_lo          = SUMW'(r_idx) < r_split;

    // Main sequencer: region sweep, command intake, scan, free-side reads and the run rewrite loop.
    always_comb begin
        n_state    = r_state;
        n_pui      = r_pui;
        n_cmd      = r_cmd;
        n_cnt      = r_cnt;
        n_pidx     = r_pidx;
        n_prev     = r_prev;
        n_idx      = r_idx;
        n_vld_d    = 1'b0;
        n_idx_d    = r_idx[AW-1:0];
        n_start    = r_start;
        n_total    = r_total;
        n_next     = r_next;
        n_split    = r_split;
        n_wend     = r_wend;
        n_len_b    = r_len_b;
        n_stamp_w  = r_stamp_w;
        n_ctr      = r_ctr;
        n_pend     = r_pend;
        n_res_sts  = r_res_sts;
        n_res_head = r_res_head;
        w_re       = 1'b0;
        w_raddr    = r_idx[AW-1:0];
        w_we       = 1'b0;
        w_waddr    = r_idx[AW-1:0];
        w_wdata    = '0;
        w_fit_clr  = 1'b0;

        unique case (r_state)
            S_CLEAR: begin
                w_we          = 1'b1;
                w_wdata.len   = r_pui;
                w_wdata.head  = (r_idx == '0);
                n_idx         = r_idx + 1'b1;
                if (r_idx == (AW + 1)'(PAGES - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_in_acc) begin
                    n_cmd  = s_axis_tuser;
                    n_cnt  = s_axis_tdata[8:0];
                    n_pidx = s_axis_tdata[16:9];
                    n_res_head = '0;
                    if (s_axis_tuser == CMD_ALLOC) begin
                        if ((s_axis_tdata[8:0] == '0) || (s_axis_tdata[8:0] > w_size)) begin
                            n_res_sts = STS_INVALID;
                            n_pend    = 1'b1;
                        end else begin
                            w_fit_clr = 1'b1;
                            n_idx     = '0;
                            n_state   = S_SCAN;
                        end
                    end else begin
                        if (CNT_W'(s_axis_tdata[16:9]) >= w_size) begin
                            n_res_sts = STS_INVALID;
                            n_pend    = 1'b1;
                        end else begin
                            w_re    = 1'b1;
                            w_raddr = AW'(s_axis_tdata[16:9]);
                            n_state = S_FP;
                        end
                    end
                end
            end
            S_SCAN: begin
                if (CW'(r_idx) < CW'(w_size)) begin
                    w_re    = 1'b1;
                    n_vld_d = 1'b1;
                    n_idx   = r_idx + 1'b1;
                end else if (!r_vld_d) begin
                    if (w_found) begin
                        n_start = w_best;
                        n_total = TOT_W'(w_best_len);
                        n_split = SUMW'(w_best) + SUMW'(r_cnt);
                        n_state = S_WSET;
                    end else begin
                        n_res_sts = STS_NOSPACE;
                        n_pend    = 1'b1;
                        n_state   = S_IDLE;
                    end
                end
            end
            S_FP: begin
                if (!w_rdata.head || !w_rdata.alloc) begin
                    n_res_sts = STS_INVALID;
                    n_pend    = 1'b1;
                    n_state   = S_IDLE;
                end else begin
                    n_start = AW'(r_pidx);
                    n_total = TOT_W'(w_rdata.len);
                    n_next  = 10'(r_pidx) + 10'(w_rdata.len);
                    if (r_pidx != '0) begin
                        w_re    = 1'b1;
                        w_raddr = AW'(r_pidx - 1'b1);
                        n_state = S_FQ;
                    end else begin
                        n_state = S_FNI;
                    end
                end
            end
            S_FQ: begin
                if ((w_rdata.len != '0) && (w_rdata.len <= CNT_W'(r_pidx))) begin
                    n_prev  = r_pidx - w_rdata.len[IDX_W-1:0];
                    w_re    = 1'b1;
                    w_raddr = AW'(r_pidx - w_rdata.len[IDX_W-1:0]);
                    n_state = S_FPREV;
                end else begin
                    n_state = S_FNI;
                end
            end
            S_FPREV: begin
                if (w_rdata.head && !w_rdata.alloc) begin
                    n_start = AW'(r_prev);
                    n_total = r_total + TOT_W'(w_rdata.len);
                end
                n_state = S_FNI;
            end
            S_FNI: begin
                if (r_next < 10'(w_size)) begin
                    w_re    = 1'b1;
                    w_raddr = AW'(r_next);
                    n_state = S_FNEXT;
                end else begin
                    n_state = S_WSET;
                end
            end
            S_FNEXT: begin
                if (w_rdata.head && !w_rdata.alloc) begin
                    n_total = r_total + TOT_W'(w_rdata.len);
                end
                n_state = S_WSET;
            end
            S_WSET: begin
                // Set up the rewrite of [start, min(start+total, PAGES)).
                n_wend    = (w_sum > SUMW'(PAGES)) ? (AW + 1)'(PAGES) : (AW + 1)'(w_sum);
                n_idx     = (AW + 1)'(r_start);
                n_stamp_w = r_ctr;
                if (r_cmd == CMD_FREE) begin
                    n_split = SUMW'(r_start);
                    n_len_b = r_total[CNT_W-1:0];
                    n_ctr   = r_ctr + 1'b1;
                end else begin
                    n_len_b = r_total[CNT_W-1:0] - r_cnt;
                    if (r_total > TOT_W'(r_cnt)) begin
                        n_ctr = r_ctr + 1'b1;
                    end
                end
                n_res_sts  = STS_OK;
                n_res_head = IDX_W'(r_start);
                n_state    = S_WRITE;
            end
            S_WRITE: begin
                if (r_idx < r_wend) begin
                    w_we          = 1'b1;
                    w_wdata.len   = w_lo ? r_cnt : r_len_b;
                    w_wdata.alloc = w_lo;
                    w_wdata.head  = (r_idx[AW-1:0] == r_start) || (SUMW'(r_idx) == r_split);
                    w_wdata.stamp = r_stamp_w;
                    n_idx         = r_idx + 1'b1;
                end else begin
                    n_pend  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // A configuration write restarts the region sweep.
        if (i_cfg_valid) begin
            n_pui   = i_cfg_data;
            n_ctr   = STAMP_W'(1);
            n_idx   = '0;
            n_pend  = 1'b0;
            n_state = S_CLEAR;
        end else if (r_pend && w_out_free) begin
            n_pend = 1'b0;
        end
    end

    // Result register toward the receiver.
    always_comb begin
        n_out_valid = r_out_valid;
        n_out_sts   = r_out_sts;
        n_out_head  = r_out_head;
        if (r_pend && w_out_free) begin
            n_out_valid = 1'b1;
            n_out_sts   = r_res_sts;
            n_out_head  = r_res_head;
        end else if (m_axis_tready) begin
            n_out_valid = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_pui       <= CNT_W'(256);
            r_idx       <= '0;
            r_vld_d     <= 1'b0;
            r_ctr       <= STAMP_W'(1);
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pui       <= n_pui;
            r_idx       <= n_idx;
            r_vld_d     <= n_vld_d;
            r_ctr       <= n_ctr;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_cnt      <= n_cnt;
        r_pidx     <= n_pidx;
        r_prev     <= n_prev;
        r_idx_d    <= n_idx_d;
        r_start    <= n_start;
        r_total    <= n_total;
        r_next     <= n_next;
        r_split    <= n_split;
        r_wend     <= n_wend;
        r_len_b    <= n_len_b;
        r_stamp_w  <= n_stamp_w;
        r_res_sts  <= n_res_sts;
        r_res_head <= n_res_head;
        r_out_sts  <= n_out_sts;
        r_out_head <= n_out_head;
    end

    // Page memory.
    pra_ram #(
        .WIDTH ($bits(t_page)),
        .DEPTH (PAGES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Best-fit tracker fed by the scan.
    pra_fit #(
        .AW (AW)
    ) u_fit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clr   (w_fit_clr),
        .i_vld   (r_vld_d),
        .i_idx   (r_idx_d),
        .i_entry (w_rdata),
        .i_cnt   (r_cnt),
        .o_found (w_found),
        .o_best  (w_best),
        .o_len   (w_best_len)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'b0, r_out_head, r_out_sts};

`ifndef SYNTHESIS
    // The page memory is written only by the sweep and the rewrite loop.
    a_we_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> ((r_state == S_CLEAR) || (r_state == S_WRITE)))
        else $error("page memory written outside sweep or rewrite");

    // The state register is always one-hot.
    a_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state))
        else $error("state register not one-hot");

    // The scan never issues past the region.
    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (CW'(r_idx) <= CW'(w_size)))
        else $error("scan index beyond region");

    // A completed rewrite always leaves a result to deliver.
    a_write_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_WRITE) && !(r_idx < r_wend) && !i_cfg_valid) |=> r_pend)
        else $error("rewrite finished without a pending result");
`endif

endmodule
